// ----- hw/rtl/ckerng_pkg.sv -----
// ----------------------------------------------------------------------------
// ckerng_pkg
// Shared types, constants and helpers for the ChaCha20 key erasure generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ckerng_pkg;

	localparam int unsigned MaxRequestBytes = 2048;
	localparam int unsigned KeyBytes = 32;
	localparam int unsigned CountW = 12;
	localparam int unsigned DoubleRounds = 10;

	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;

	localparam logic ReqAbsorb = 1'b0;
	localparam logic ReqGenerate = 1'b1;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] blk_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic absorb_mix;
		logic load;
		logic round_even;
		logic round_odd;
		logic finish;
	} cmd_t;

	function automatic word_t rotl(input word_t v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] qr(input word_t a, input word_t b,
			input word_t c, input word_t d);
		word_t a1, b1, c1, d1;
		a1 = a + b; d1 = rotl(d ^ a1, 16);
		c1 = c + d1; b1 = rotl(b ^ c1, 12);
		a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
		c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
		qr = {d1, c1, b1, a1};
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chacha20_key_erasure_rng.sv -----
// ----------------------------------------------------------------------------
// chacha20_key_erasure_rng
// ChaCha20 random generator with fast key erasure.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one beat per request. With req_type low the
// beat absorbs up to 32 entropy bytes into the key and runs one block; no
// output beat follows. With req_type high it requests byte_count random
// bytes, capped at MAX_REQUEST_BYTES, returned as one output beat per 32-byte
// block, the final beat flagged by last_block and valid_bytes giving the
// bytes that count. Each block runs a load, twenty half double rounds that
// alternate a column and a diagonal round unit, and one finishing add and
// key update. A generate request runs its blocks in turn, each one waiting
// until its output beat is taken before the next block starts.
// The input is stalled while a request is in progress. When the receiver
// stalls, the finished block waits in the output register and no further
// block is started. Reset clears the key and counter to zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_key_erasure_rng #(
	parameter int unsigned MAX_REQUEST_BYTES = ckerng_pkg::MaxRequestBytes
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [63:0] entropy_w0,
	input  wire logic [63:0] entropy_w1,
	input  wire logic [63:0] entropy_w2,
	input  wire logic [63:0] entropy_w3,
	input  wire logic [11:0] byte_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      rand_w0,
	output logic [63:0]      rand_w1,
	output logic [63:0]      rand_w2,
	output logic [63:0]      rand_w3,
	output logic [5:0]       valid_bytes,
	output logic             last_block
);

	ckerng_pkg::cmd_t cmd;
	logic absorb;
	logic [5:0] ent_len;
	logic [255:0] rand_bits;

	ckerng_ctrl #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .byte_count(byte_count), .out_valid(out_valid),
		.out_stall(out_stall), .valid_bytes(valid_bytes), .last_block(last_block),
		.cmd(cmd), .absorb(absorb), .ent_len(ent_len)
	);

	ckerng_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .absorb(absorb),
		.entropy({entropy_w3, entropy_w2, entropy_w1, entropy_w0}),
		.ent_len(ent_len), .rand_bits(rand_bits)
	);

	assign rand_w0 = rand_bits[63:0];
	assign rand_w1 = rand_bits[127:64];
	assign rand_w2 = rand_bits[191:128];
	assign rand_w3 = rand_bits[255:192];

endmodule

`default_nettype wire

// ----- hw/rtl/ckerng_datapath.sv -----
// ----------------------------------------------------------------------------
// ckerng_datapath
// Key, counter and ChaCha20 working state; one half double round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ckerng_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ckerng_pkg::cmd_t    cmd,
	input  wire logic                absorb,
	input  wire logic [255:0]        entropy,
	input  wire logic [5:0]          ent_len,
	output logic [255:0]             rand_bits
);

	ckerng_pkg::word_t [7:0] key_q;
	logic [63:0] ctr_q;
	ckerng_pkg::blk_t x_q;
	ckerng_pkg::blk_t init_w;
	ckerng_pkg::blk_t col_w;
	ckerng_pkg::blk_t diag_w;
	ckerng_pkg::blk_t sum_w;
	logic [255:0] rand_q;
	logic [255:0] mask_w;

	always_comb begin
		init_w[0] = ckerng_pkg::Sigma0;
		init_w[1] = ckerng_pkg::Sigma1;
		init_w[2] = ckerng_pkg::Sigma2;
		init_w[3] = ckerng_pkg::Sigma3;
		for (int i = 0; i < 8; i++) begin
			init_w[4 + i] = key_q[i];
		end
		init_w[12] = ctr_q[31:0];
		init_w[13] = ctr_q[63:32];
		init_w[14] = '0;
		init_w[15] = '0;
	end

	always_comb begin
		col_w = x_q;
		for (int i = 0; i < 4; i++) begin
			{col_w[12 + i], col_w[8 + i], col_w[4 + i], col_w[i]} =
				ckerng_pkg::qr(x_q[i], x_q[4 + i], x_q[8 + i], x_q[12 + i]);
		end
		diag_w = x_q;
		for (int i = 0; i < 4; i++) begin
			{diag_w[12 + (i + 3) % 4], diag_w[8 + (i + 2) % 4],
				diag_w[4 + (i + 1) % 4], diag_w[i]} =
				ckerng_pkg::qr(x_q[i], x_q[4 + (i + 1) % 4],
					x_q[8 + (i + 2) % 4], x_q[12 + (i + 3) % 4]);
		end
		for (int i = 0; i < 16; i++) begin
			sum_w[i] = x_q[i] + init_w[i];
		end
		for (int i = 0; i < 32; i++) begin
			mask_w[i*8 +: 8] = (6'(i) < ent_len) ? 8'hff : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			ctr_q <= '0;
		end else if (cmd.absorb_mix) begin
			key_q <= key_q ^ (entropy & mask_w);
		end else if (cmd.finish) begin
			for (int i = 0; i < 8; i++) begin
				key_q[i] <= key_q[i] ^ sum_w[i] ^ (absorb ? sum_w[8 + i] : 32'h0);
			end
			ctr_q <= ctr_q + 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= init_w;
		end else if (cmd.round_even) begin
			x_q <= col_w;
		end else if (cmd.round_odd) begin
			x_q <= diag_w;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 8; i++) begin
				rand_q[i*32 +: 32] <= sum_w[8 + i];
			end
		end
	end

	assign rand_bits = rand_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ckerng_ctrl.sv -----
// ----------------------------------------------------------------------------
// ckerng_ctrl
// Sequencer for absorb and generate requests and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ckerng_ctrl #(
	parameter int unsigned MAX_REQUEST_BYTES = ckerng_pkg::MaxRequestBytes
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                req_type,
	input  wire logic [11:0]         byte_count,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [5:0]               valid_bytes,
	output logic                     last_block,
	output ckerng_pkg::cmd_t         cmd,
	output logic                     absorb,
	output logic [5:0]               ent_len
);

	ckerng_pkg::state_t state_q, state_d;
	logic [4:0] rnd_q;
	logic [11:0] rem_q;
	logic absorb_q;
	logic ov_q;
	logic [5:0] vb_q;
	logic last_q;
	logic acc;
	logic [11:0] req_len;
	logic [11:0] take;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != ckerng_pkg::ST_IDLE);
	assign req_len = (byte_count > 12'(MAX_REQUEST_BYTES)) ? 12'(MAX_REQUEST_BYTES) : byte_count;
	assign take = (rem_q < 12'd32) ? rem_q : 12'd32;
	assign ent_len = (byte_count > 12'd32) ? 6'd32 : byte_count[5:0];
	assign absorb = absorb_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ckerng_pkg::ST_IDLE: begin
				if (acc && byte_count != 12'd0) begin
					state_d = ckerng_pkg::ST_LOAD;
				end
			end
			ckerng_pkg::ST_LOAD: state_d = ckerng_pkg::ST_ROUND;
			ckerng_pkg::ST_ROUND: begin
				if (rnd_q == 5'd19) begin
					state_d = ckerng_pkg::ST_FINISH;
				end
			end
			ckerng_pkg::ST_FINISH: begin
				if (absorb_q) begin
					state_d = ckerng_pkg::ST_IDLE;
				end else begin
					state_d = ckerng_pkg::ST_OUT;
				end
			end
			ckerng_pkg::ST_OUT: begin
				if (!ov_q) begin
					state_d = (rem_q == 12'd0) ? ckerng_pkg::ST_IDLE : ckerng_pkg::ST_LOAD;
				end
			end
			default: state_d = ckerng_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ckerng_pkg::ST_IDLE: cmd.absorb_mix = acc && req_type == ckerng_pkg::ReqAbsorb
				&& byte_count != 12'd0;
			ckerng_pkg::ST_LOAD: cmd.load = 1'b1;
			ckerng_pkg::ST_ROUND: begin
				cmd.round_even = !rnd_q[0];
				cmd.round_odd = rnd_q[0];
			end
			ckerng_pkg::ST_FINISH: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ckerng_pkg::ST_IDLE;
			rnd_q <= '0;
			rem_q <= '0;
			absorb_q <= 1'b0;
			ov_q <= 1'b0;
			vb_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				absorb_q <= (req_type == ckerng_pkg::ReqAbsorb);
				rem_q <= req_len;
			end
			if (state_q == ckerng_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 5'd1;
			end else begin
				rnd_q <= '0;
			end
			if (state_q == ckerng_pkg::ST_FINISH && !absorb_q) begin
				ov_q <= 1'b1;
				vb_q <= take[5:0];
				rem_q <= rem_q - take;
				last_q <= (rem_q == take);
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign valid_bytes = vb_q;
	assign last_block = last_q;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ChaCha20 key erasure generator. A behavioural
// model of the key and counter predicts every output beat; directed cases
// cover the edges of the entropy count and the request size, then random
// absorb and generate requests run with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] w [4];
		logic [5:0]  nbytes;
		logic        last;
	} rand_blk_t;

	logic clk, arst_n;
	logic in_valid, in_stall, req_type;
	logic [63:0] entropy_w0, entropy_w1, entropy_w2, entropy_w3;
	logic [11:0] byte_count;
	logic out_valid, out_stall;
	logic [63:0] rand_w0, rand_w1, rand_w2, rand_w3;
	logic [5:0] valid_bytes;
	logic last_block;

	chacha20_key_erasure_rng DUT (.*);

	logic [31:0] key_state [8];
	logic [63:0] ctr_state;
	rand_blk_t   pending_blocks [$];
	int          n_fail, n_beats_in, n_blocks_out, n_absorbs;
	int          sender_idle_pct, receiver_idle_pct;
	bit          hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic mix(inout logic [31:0] s [16], input int a, b, c, d);
		s[a] += s[b]; s[d] = rl(s[d] ^ s[a], 16);
		s[c] += s[d]; s[b] = rl(s[b] ^ s[c], 12);
		s[a] += s[b]; s[d] = rl(s[d] ^ s[a], 8);
		s[c] += s[d]; s[b] = rl(s[b] ^ s[c], 7);
	endtask

	task automatic run_block(output logic [31:0] o [16]);
		logic [31:0] ini [16];
		logic [31:0] s [16];
		ini[0] = ckerng_pkg::Sigma0; ini[1] = ckerng_pkg::Sigma1;
		ini[2] = ckerng_pkg::Sigma2; ini[3] = ckerng_pkg::Sigma3;
		for (int i = 0; i < 8; i++) ini[4 + i] = key_state[i];
		ini[12] = ctr_state[31:0];
		ini[13] = ctr_state[63:32];
		ini[14] = '0;
		ini[15] = '0;
		s = ini;
		for (int r = 0; r < 10; r++) begin
			mix(s, 0, 4, 8, 12); mix(s, 1, 5, 9, 13);
			mix(s, 2, 6, 10, 14); mix(s, 3, 7, 11, 15);
			mix(s, 0, 5, 10, 15); mix(s, 1, 6, 11, 12);
			mix(s, 2, 7, 8, 13); mix(s, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) o[i] = s[i] + ini[i];
		for (int i = 0; i < 8; i++) key_state[i] ^= o[i];
		ctr_state++;
	endtask

	task automatic predict_request(logic rt, logic [63:0] e [4], logic [11:0] cnt);
		logic [31:0] o [16];
		int          len, take;
		rand_blk_t   b;
		len = cnt;
		if (rt == ckerng_pkg::ReqAbsorb) begin
			if (len == 0) return;
			if (len > ckerng_pkg::KeyBytes) len = ckerng_pkg::KeyBytes;
			for (int i = 0; i < len; i++)
				key_state[i / 4] ^= 32'(e[i / 8][(i % 8) * 8 +: 8]) << ((i % 4) * 8);
			run_block(o);
			for (int i = 0; i < 8; i++) key_state[i] ^= o[8 + i];
			return;
		end
		if (len > ckerng_pkg::MaxRequestBytes) len = ckerng_pkg::MaxRequestBytes;
		while (len != 0) begin
			take = len < ckerng_pkg::KeyBytes ? len : ckerng_pkg::KeyBytes;
			run_block(o);
			for (int j = 0; j < 4; j++) b.w[j] = {o[9 + 2 * j], o[8 + 2 * j]};
			b.nbytes = 6'(take);
			len -= take;
			b.last = (len == 0);
			pending_blocks.push_back(b);
		end
	endtask

	task automatic send_request(logic rt, logic [63:0] e [4], logic [11:0] cnt);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		entropy_w0 <= e[0]; entropy_w1 <= e[1];
		entropy_w2 <= e[2]; entropy_w3 <= e[3];
		byte_count <= cnt;
		do @(posedge clk); while (in_stall);
		predict_request(rt, e, cnt);
		n_beats_in++;
		if (rt == ckerng_pkg::ReqAbsorb) n_absorbs++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] r64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_random(logic rt, logic [11:0] cnt);
		logic [63:0] e [4];
		for (int j = 0; j < 4; j++) e[j] = r64();
		send_request(rt, e, cnt);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_blocks.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	always @(posedge clk) begin
		rand_blk_t b;
		if (arst_n && out_valid && !out_stall) begin
			n_blocks_out++;
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected output beat rand_w0=%h", $time, rand_w0);
				n_fail++;
			end else begin
				b = pending_blocks.pop_front();
				if ({rand_w3, rand_w2, rand_w1, rand_w0} != {b.w[3], b.w[2], b.w[1], b.w[0]}) begin
					$display("%0t: random data expected %h_%h_%h_%h actual %h_%h_%h_%h",
						$time, b.w[3], b.w[2], b.w[1], b.w[0],
						rand_w3, rand_w2, rand_w1, rand_w0);
					n_fail++;
				end
				if (valid_bytes != b.nbytes) begin
					$display("%0t: valid_bytes expected %0d actual %0d",
						$time, b.nbytes, valid_bytes);
					n_fail++;
				end
				if (last_block != b.last) begin
					$display("%0t: last_block expected %0b actual %0b",
						$time, b.last, last_block);
					n_fail++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	task automatic test_directed();
		logic [63:0] ones [4];
		logic [63:0] zeros [4];
		for (int j = 0; j < 4; j++) begin
			ones[j] = '1;
			zeros[j] = '0;
		end
		send_request(ckerng_pkg::ReqGenerate, zeros, 12'd32);
		send_request(ckerng_pkg::ReqGenerate, zeros, 12'd1);
		send_request(ckerng_pkg::ReqGenerate, zeros, 12'd0);
		send_request(ckerng_pkg::ReqAbsorb, ones, 12'd0);
		send_request(ckerng_pkg::ReqAbsorb, ones, 12'd1);
		send_request(ckerng_pkg::ReqAbsorb, ones, 12'd31);
		send_request(ckerng_pkg::ReqAbsorb, ones, 12'd32);
		send_request(ckerng_pkg::ReqAbsorb, ones, 12'd33);
		send_request(ckerng_pkg::ReqAbsorb, zeros, 12'hFFF);
		send_random(ckerng_pkg::ReqAbsorb, 12'd17);
		send_request(ckerng_pkg::ReqGenerate, ones, 12'd31);
		send_request(ckerng_pkg::ReqGenerate, ones, 12'd33);
		send_request(ckerng_pkg::ReqGenerate, zeros, 12'd64);
		send_request(ckerng_pkg::ReqGenerate, zeros, 12'd2048);
		send_request(ckerng_pkg::ReqGenerate, zeros, 12'hFFF);
		send_request(ckerng_pkg::ReqGenerate, zeros, 12'd2049);
		drain();
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				send_random(ckerng_pkg::ReqGenerate, 12'd40);
				send_random(ckerng_pkg::ReqAbsorb, 12'd32);
				send_random(ckerng_pkg::ReqGenerate, 12'd5);
			end
			begin
				for (int c = 0; c < 400; c++) @(negedge clk);
				hold_off = 1'b0;
			end
		join
		drain();
	endtask

	task automatic test_random(int n_items, bit bursty);
		logic [11:0] cnt;
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(9))
				0: cnt = 12'($urandom);
				1, 2: cnt = 12'($urandom_range(1, 32));
				default: cnt = 12'($urandom_range(1, 100));
			endcase
			if ($urandom_range(1)) send_random(ckerng_pkg::ReqGenerate, cnt);
			else send_random(ckerng_pkg::ReqAbsorb, cnt);
			if (bursty && $urandom_range(30) == 0) drain();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = ckerng_pkg::ReqAbsorb;
		entropy_w0 = '0; entropy_w1 = '0; entropy_w2 = '0; entropy_w3 = '0;
		byte_count = '0;
		out_stall = 1'b0;
		hold_off = 1'b0;
		sender_idle_pct = 37;
		receiver_idle_pct = 37;
		for (int i = 0; i < 8; i++) key_state[i] = '0;
		ctr_state = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(200, 1'b1);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_random(50, 1'b0);
		$display("Covered %0d request beats (%0d absorbs) and %0d output blocks.",
			n_beats_in, n_absorbs, n_blocks_out);
		if (n_fail == 0) $display("PASS chacha20_key_erasure_rng");
		else $display("FAIL chacha20_key_erasure_rng");
		$finish;
	end

	initial begin
		#50ms;
		$display("Timed out waiting for the generator.");
		$display("FAIL chacha20_key_erasure_rng");
		$finish;
	end

endmodule

`default_nettype wire
